>>> sv/device_presence_table_core_defines.svh
// Assertion macros for the device presence table.
// Included by the top level; depends on nothing else.
`ifndef DEVICE_PRESENCE_TABLE_CORE_DEFINES_SVH
`define DEVICE_PRESENCE_TABLE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define DPT_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define DPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DPT_ASSERT_RST(lbl, clk, rstn, prop, msg)
`define DPT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> sv/dpt_pkg.sv
// Shared types and constants of the device presence table.
// Used by dpt_cell and device_presence_table_core; depends on nothing.
package dpt_pkg;

    localparam int DEF_ENTRIES   = 64;
    localparam int DEF_TIME_BITS = 40;

    localparam int NOW_W   = 40;
    localparam int SIG_W   = 8;
    localparam int KIND_W  = 2;
    localparam int ADDR_W  = 48;
    localparam int CFG_W   = 32;
    localparam int COUNT_W = 7;

    localparam logic signed [SIG_W-1:0] SIG_UNKNOWN   = 8'sd127;
    localparam logic signed [SIG_W-1:0] MIN_SIG_RESET = -8'sd85;
    localparam logic [CFG_W-1:0]        RET_RESET     = 32'd600000;
    localparam logic [COUNT_W-1:0]      COUNT_MAX     = 7'd127;

    localparam logic OP_SIGHT = 1'b0;
    localparam logic OP_SWEEP = 1'b1;

    localparam logic [0:0] REG_MIN_SIG   = 1'b0;
    localparam logic [0:0] REG_RETENTION = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_WALK   = 3'b010,
        S_FINISH = 3'b100
    } t_state;

    typedef struct packed {
        logic              op;
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] addr;
    } t_query;

endpackage

>>> sv/dpt_cell.sv
// One table entry with its share of the search that walks down the row.
// Depends on dpt_pkg; the token type comes from the top level.
module dpt_cell #(
    parameter int  ENTRIES   = dpt_pkg::DEF_ENTRIES,
    parameter int  TIME_BITS = dpt_pkg::DEF_TIME_BITS,
    parameter int  CELL_IDX  = 0,
    parameter type t_tok     = logic
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dpt_pkg::t_query               i_query,
    input  logic [TIME_BITS-1:0]          i_now,
    input  logic [dpt_pkg::CFG_W-1:0]     i_ret,
    input  logic                          i_wr_en,
    input  logic [((ENTRIES > 1) ? $clog2(ENTRIES) : 1)-1:0] i_wr_idx,
    input  logic                          i_tv,
    input  t_tok                          i_tok,
    output logic                          o_tv,
    output t_tok                          o_tok
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    logic                       r_valid;
    logic [dpt_pkg::KIND_W-1:0] r_kind;
    logic [dpt_pkg::ADDR_W-1:0] r_addr;
    logic [TIME_BITS-1:0]       r_seen;
    logic                       r_tv;
    t_tok                       r_tok;
    t_tok                       n_tok;
    logic                       w_active;
    logic                       w_match;
    logic [TIME_BITS-1:0]       w_age;
    logic                       w_hit;

    assign w_age    = i_now - r_seen;
    assign w_active = r_valid && ((i_now < r_seen) || (w_age <= TIME_BITS'(i_ret)));
    assign w_match  = r_valid && (r_kind == i_query.kind) && (r_addr == i_query.addr);
    assign w_hit    = i_wr_en && (i_wr_idx == IW'(CELL_IDX));

    always_comb begin
        n_tok       = i_tok;
        n_tok.count = i_tok.count + CW'(w_active);
        if (w_match && !i_tok.match) begin
            n_tok.match     = 1'b1;
            n_tok.match_act = w_active;
            n_tok.match_idx = IW'(CELL_IDX);
        end
        if (!r_valid && !i_tok.free_found) begin
            n_tok.free_found = 1'b1;
            n_tok.free_idx   = IW'(CELL_IDX);
        end
        if (r_valid && (!i_tok.have_old || (r_seen < i_tok.old_seen))) begin
            n_tok.have_old = 1'b1;
            n_tok.old_act  = w_active;
            n_tok.old_seen = r_seen;
            n_tok.old_idx  = IW'(CELL_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tv    <= 1'b0;
        end else begin
            r_tv <= i_tv;
            if (w_hit) begin
                r_valid <= 1'b1;
            end else if (i_tv && (i_query.op == dpt_pkg::OP_SWEEP) && r_valid && !w_active) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tv) begin
            r_tok <= n_tok;
        end
        if (w_hit) begin
            r_kind <= i_query.kind;
            r_addr <= i_query.addr;
            r_seen <= i_now;
        end
    end

    assign o_tv  = r_tv;
    assign o_tok = r_tok;

endmodule

>>> sv/device_presence_table_core.sv
// Top level of the device presence table: control, registers and the cell row.
// Depends on dpt_pkg, dpt_cell and device_presence_table_core_defines.svh.
//
//  channel | valid       | stall       | payload
//  input   | i_in_valid  | o_in_stall  | i_op i_now_ms i_signal_dbm i_addr_kind i_device_addr
//  output  | o_out_valid | i_out_stall | o_active_count o_count_changed o_accepted
//  config  | i_cfg_wr_en | (none)      | i_cfg_index i_cfg_wdata
//
// For each word, one search token walks the row of cells, one cell per cycle,
// and the table write and result follow when the output register is free.
// Reset clears all entries at once; there is no clearing pass.
// A new word is taken while a result waits, but the word finishes only when
// the output register is free.
`include "device_presence_table_core_defines.svh"

module device_presence_table_core #(
    parameter int ENTRIES   = dpt_pkg::DEF_ENTRIES,
    parameter int TIME_BITS = dpt_pkg::DEF_TIME_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_op,
    input  logic [dpt_pkg::NOW_W-1:0]           i_now_ms,
    input  logic signed [dpt_pkg::SIG_W-1:0]    i_signal_dbm,
    input  logic [dpt_pkg::KIND_W-1:0]          i_addr_kind,
    input  logic [dpt_pkg::ADDR_W-1:0]          i_device_addr,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [dpt_pkg::COUNT_W-1:0]         o_active_count,
    output logic                                o_count_changed,
    output logic                                o_accepted,
    input  logic                                i_cfg_wr_en,
    input  logic [0:0]                          i_cfg_index,
    input  logic [dpt_pkg::CFG_W-1:0]           i_cfg_wdata
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int XW = CW + 8;

    typedef struct packed {
        logic [CW-1:0]        count;
        logic                 match;
        logic                 match_act;
        logic [IW-1:0]        match_idx;
        logic                 free_found;
        logic [IW-1:0]        free_idx;
        logic                 have_old;
        logic                 old_act;
        logic [TIME_BITS-1:0] old_seen;
        logic [IW-1:0]        old_idx;
    } t_tok;

    dpt_pkg::t_state                   r_state;
    dpt_pkg::t_state                   n_state;
    logic signed [dpt_pkg::SIG_W-1:0]  r_min_sig;
    logic [dpt_pkg::CFG_W-1:0]         r_ret;
    dpt_pkg::t_query                   r_query;
    logic [TIME_BITS-1:0]              r_now;
    logic                              r_acc;
    logic                              r_start;
    logic [dpt_pkg::COUNT_W-1:0]       r_reported;
    logic                              r_out_valid;
    logic [dpt_pkg::COUNT_W-1:0]       r_out_count;
    logic                              r_out_changed;
    logic                              r_out_acc;

    logic                              w_in_acc;
    logic                              w_pass;
    logic                              w_out_free;
    logic                              w_finish;
    logic                              w_wr_en;
    logic [IW-1:0]                     w_wr_idx;
    logic [CW-1:0]                     w_cnt;
    logic [dpt_pkg::COUNT_W-1:0]       w_sat;
    logic [ENTRIES:0]                  w_tv;
    t_tok                              w_tok [ENTRIES+1];
    t_tok                              w_last;

    assign o_in_stall = (r_state != dpt_pkg::S_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_pass     = (i_op == dpt_pkg::OP_SIGHT) && (i_signal_dbm != dpt_pkg::SIG_UNKNOWN)
                        && (i_signal_dbm >= r_min_sig);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_finish   = (r_state == dpt_pkg::S_FINISH) && w_out_free;
    assign w_last     = w_tok[ENTRIES];

    always_comb begin
        w_cnt    = w_last.count;
        w_wr_idx = w_last.old_idx;
        if (r_acc) begin
            if (w_last.match) begin
                w_wr_idx = w_last.match_idx;
                w_cnt    = w_last.count - CW'(w_last.match_act) + CW'(1);
            end else if (w_last.free_found) begin
                w_wr_idx = w_last.free_idx;
                w_cnt    = w_last.count + CW'(1);
            end else begin
                w_wr_idx = w_last.old_idx;
                w_cnt    = w_last.count - CW'(w_last.old_act) + CW'(1);
            end
        end
    end

    assign w_sat   = (XW'(w_cnt) > XW'(dpt_pkg::COUNT_MAX)) ? dpt_pkg::COUNT_MAX
                                                           : dpt_pkg::COUNT_W'(w_cnt);
    assign w_wr_en = w_finish && r_acc;

    always_comb begin
        n_state = r_state;
        case (r_state)
            dpt_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    n_state = dpt_pkg::S_WALK;
                end
            end
            dpt_pkg::S_WALK: begin
                if (w_tv[ENTRIES]) begin
                    n_state = dpt_pkg::S_FINISH;
                end
            end
            dpt_pkg::S_FINISH: begin
                if (w_out_free) begin
                    n_state = dpt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dpt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dpt_pkg::S_IDLE;
            r_min_sig   <= dpt_pkg::MIN_SIG_RESET;
            r_ret       <= dpt_pkg::RET_RESET;
            r_start     <= 1'b0;
            r_reported  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_start <= w_in_acc;
            if (i_cfg_wr_en) begin
                if (i_cfg_index == dpt_pkg::REG_MIN_SIG) begin
                    r_min_sig <= i_cfg_wdata[dpt_pkg::SIG_W-1:0];
                end else if (i_cfg_index == dpt_pkg::REG_RETENTION) begin
                    r_ret <= i_cfg_wdata;
                end
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
                r_reported  <= w_sat;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_query.op   <= i_op;
            r_query.kind <= i_addr_kind;
            r_query.addr <= i_device_addr;
            r_now        <= TIME_BITS'(i_now_ms);
            r_acc        <= w_pass;
        end
        if (w_finish) begin
            r_out_count   <= w_sat;
            r_out_changed <= (w_sat != r_reported);
            r_out_acc     <= r_acc;
        end
    end

    assign w_tv[0]  = r_start;
    assign w_tok[0] = '0;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        dpt_cell #(
            .ENTRIES   (ENTRIES),
            .TIME_BITS (TIME_BITS),
            .CELL_IDX  (g),
            .t_tok     (t_tok)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_query  (r_query),
            .i_now    (r_now),
            .i_ret    (r_ret),
            .i_wr_en  (w_wr_en),
            .i_wr_idx (w_wr_idx),
            .i_tv     (w_tv[g]),
            .i_tok    (w_tok[g]),
            .o_tv     (w_tv[g+1]),
            .o_tok    (w_tok[g+1])
        );
    end

    assign o_out_valid     = r_out_valid;
    assign o_active_count  = r_out_count;
    assign o_count_changed = r_out_changed;
    assign o_accepted      = r_out_acc;

    `DPT_ASSERT_RST(a_start_after_accept, i_clk, i_rst_n, w_in_acc |=> r_start, "accepted word did not start a walk")
    `DPT_ASSERT_RST(a_one_token, i_clk, i_rst_n, $onehot0(w_tv), "more than one search token in the row")
    `DPT_ASSERT_RST(a_token_in_walk, i_clk, i_rst_n, w_tv[ENTRIES] |-> (r_state == dpt_pkg::S_WALK), "search ended outside a walk")
    `DPT_ASSERT_RST(a_write_when_free, i_clk, i_rst_n, w_wr_en |-> w_out_free, "table written while result is blocked")

endmodule

>>> dv/device_presence_table_core_tb.sv
// Self-checking testbench for device_presence_table_core: directed and random words are
// checked against a table model kept inside the bench, under random idling and stalls.
// Depends on dpt_pkg and the device_presence_table_core RTL.
module device_presence_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dpt_pkg::*;

    localparam int N_ENTRIES   = 64;
    localparam int POOL        = 80;
    localparam int HOLD_CYCLES = 600;
    localparam int TAIL_CYCLES = 2 * (N_ENTRIES + 3);
    localparam int LIMIT       = 500000;

    typedef struct {
        logic                    op;
        logic [NOW_W-1:0]        now;
        logic signed [SIG_W-1:0] sig;
        logic [KIND_W-1:0]       kind;
        logic [ADDR_W-1:0]       addr;
    } table_word_t;

    typedef struct {
        logic [COUNT_W-1:0] count;
        logic               changed;
        logic               accepted;
    } presence_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [COUNT_W-1:0]      active_count;
    logic                    count_changed;
    logic                    accepted;
    logic                    cfg_wr_en = 1'b0;
    logic [0:0]              cfg_index = REG_MIN_SIG;
    logic [CFG_W-1:0]        cfg_wdata = '0;

    table_word_t             cur_word = '{default: '0};
    table_word_t             pending_words[$];
    presence_t               expected_reports[$];

    bit                      tbl_valid[N_ENTRIES];
    logic [KIND_W-1:0]       tbl_kind[N_ENTRIES];
    logic [ADDR_W-1:0]       tbl_addr[N_ENTRIES];
    logic [NOW_W-1:0]        tbl_seen[N_ENTRIES];
    logic [COUNT_W-1:0]      last_count = '0;
    logic signed [SIG_W-1:0] cur_min_sig = MIN_SIG_RESET;
    logic [CFG_W-1:0]        cur_retention = RET_RESET;

    logic [KIND_W-1:0]       dev_kind[POOL];
    logic [ADDR_W-1:0]       dev_addr[POOL];
    logic [NOW_W-1:0]        clock_ms = '0;

    bit                      word_taken = 1'b0;
    bit                      hold_req = 1'b0;
    int unsigned             hold_left = 0;
    int unsigned             idle_pct = 35;
    int unsigned             cycles = 0;
    int unsigned             errors = 0;

    device_presence_table_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_op           (cur_word.op),
        .i_now_ms       (cur_word.now),
        .i_signal_dbm   (cur_word.sig),
        .i_addr_kind    (cur_word.kind),
        .i_device_addr  (cur_word.addr),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_active_count (active_count),
        .o_count_changed(count_changed),
        .o_accepted     (accepted),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_index    (cfg_index),
        .i_cfg_wdata    (cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [NOW_W-1:0] age_at(input logic [NOW_W-1:0] now,
                                                input logic [NOW_W-1:0] seen);
        return (now >= seen) ? now - seen : '0;
    endfunction

    function automatic presence_t update_presence(input table_word_t w);
        presence_t r;
        int        open_slot;
        int        old_slot;
        int        slot;
        int        n;
        bit        hit;
        r.accepted = 1'b0;
        if (w.op == OP_SWEEP) begin
            for (int i = 0; i < N_ENTRIES; i++) begin
                if (tbl_valid[i] && age_at(w.now, tbl_seen[i]) > cur_retention) begin
                    tbl_valid[i] = 1'b0;
                end
            end
        end else if (w.sig != SIG_UNKNOWN && w.sig >= cur_min_sig) begin
            r.accepted = 1'b1;
            hit = 1'b0;
            open_slot = -1;
            old_slot = -1;
            for (int i = 0; i < N_ENTRIES; i++) begin
                if (tbl_valid[i]) begin
                    if (!hit && tbl_kind[i] == w.kind && tbl_addr[i] == w.addr) begin
                        tbl_seen[i] = w.now;
                        hit = 1'b1;
                    end else if (old_slot < 0 || tbl_seen[i] < tbl_seen[old_slot]) begin
                        old_slot = i;
                    end
                end else if (open_slot < 0) begin
                    open_slot = i;
                end
            end
            if (!hit) begin
                slot = (open_slot >= 0) ? open_slot : old_slot;
                tbl_valid[slot] = 1'b1;
                tbl_kind[slot] = w.kind;
                tbl_addr[slot] = w.addr;
                tbl_seen[slot] = w.now;
            end
        end
        n = 0;
        for (int i = 0; i < N_ENTRIES; i++) begin
            if (tbl_valid[i] && age_at(w.now, tbl_seen[i]) <= cur_retention) begin
                n++;
            end
        end
        r.count = (n > COUNT_MAX) ? COUNT_MAX : n[COUNT_W-1:0];
        r.changed = (r.count != last_count);
        last_count = r.count;
        return r;
    endfunction

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Words are predicted in order of acceptance.
    always @(posedge i_clk) begin
        if (i_rst_n && in_valid && !in_stall) begin
            expected_reports.push_back(update_presence(cur_word));
            word_taken = 1'b1;
        end
    end

    always @(negedge i_clk) begin
        if (!in_valid || word_taken) begin
            word_taken = 1'b0;
            if (pending_words.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                cur_word = pending_words.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < idle_pct);
        end
    end

    always @(posedge i_clk) begin
        presence_t exp_r;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_reports.size() == 0) begin
                $error("unexpected result word: active_count %0d", active_count);
                errors++;
            end else begin
                exp_r = expected_reports.pop_front();
                if (active_count !== exp_r.count) begin
                    $error("active_count: expected %0d, got %0d", exp_r.count, active_count);
                    errors++;
                end
                if (count_changed !== exp_r.changed) begin
                    $error("count_changed: expected %0d, got %0d", exp_r.changed,
                           count_changed);
                    errors++;
                end
                if (accepted !== exp_r.accepted) begin
                    $error("accepted: expected %0d, got %0d", exp_r.accepted, accepted);
                    errors++;
                end
            end
        end
    end

    task automatic queue_word(input logic op, input logic [NOW_W-1:0] now,
                              input logic signed [SIG_W-1:0] sig,
                              input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr);
        table_word_t w;
        w.op = op;
        w.now = now;
        w.sig = sig;
        w.kind = kind;
        w.addr = addr;
        pending_words.push_back(w);
    endtask

    task automatic queue_sweep(input logic [NOW_W-1:0] now);
        queue_word(OP_SWEEP, now, SIG_W'($urandom), KIND_W'($urandom),
                   ADDR_W'({$urandom, $urandom}));
    endtask

    task automatic wait_idle();
        while (pending_words.size() > 0 || in_valid || expected_reports.size() > 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] data);
        wait_idle();
        @(negedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_MIN_SIG) begin
            cur_min_sig = data[SIG_W-1:0];
        end else begin
            cur_retention = data;
        end
    endtask

    task automatic write_min_sig(input int dbm);
        logic signed [SIG_W-1:0] v;
        v = SIG_W'(dbm);
        write_reg(REG_MIN_SIG, {{(CFG_W-SIG_W){v[SIG_W-1]}}, v});
    endtask

    // Mostly sightings of a pool slightly larger than the table, so entries are
    // refreshed, fill the table and get evicted; time mostly moves forward.
    task automatic queue_random(input int count);
        int unsigned pick;
        int unsigned span;
        int          lo;
        logic signed [SIG_W-1:0] sig;
        int          d;
        for (int k = 0; k < count; k++) begin
            span = cur_retention / 16 + 2;
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                clock_ms = clock_ms - NOW_W'($urandom_range(0, 5000));
            end else if (pick < 8) begin
                clock_ms = clock_ms + NOW_W'(cur_retention) + NOW_W'($urandom_range(1, 3000));
            end else if (pick >= 35) begin
                clock_ms = clock_ms + NOW_W'($urandom_range(0, span - 1));
            end
            if ($urandom_range(0, 99) < 15) begin
                queue_sweep(clock_ms);
            end else begin
                pick = $urandom_range(0, 99);
                lo = int'(cur_min_sig);
                if (pick < 10) begin
                    sig = SIG_UNKNOWN;
                end else if (pick < 25) begin
                    sig = SIG_W'($urandom);
                end else begin
                    sig = SIG_W'(lo + int'($urandom_range(0, 126 - lo)));
                end
                if ($urandom_range(0, 99) < 12) begin
                    queue_word(OP_SIGHT, clock_ms, sig, KIND_W'($urandom),
                               ADDR_W'({$urandom, $urandom}));
                end else begin
                    d = int'($urandom_range(0, POOL - 1));
                    queue_word(OP_SIGHT, clock_ms, sig, dev_kind[d], dev_addr[d]);
                end
            end
        end
    endtask

    initial begin
        for (int i = 0; i < N_ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_kind[i] = '0;
            tbl_addr[i] = '0;
            tbl_seen[i] = '0;
        end
        for (int i = 0; i < POOL; i++) begin
            dev_kind[i] = KIND_W'($urandom);
            dev_addr[i] = ADDR_W'({$urandom, $urandom});
        end
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_word(OP_SIGHT, 40'd1000, -8'sd60, 2'd0, 48'h0);
        queue_word(OP_SIGHT, 40'd1000, SIG_UNKNOWN, 2'd1, 48'h1);
        queue_word(OP_SIGHT, 40'd1001, 8'sh80, 2'd1, 48'h2);
        queue_word(OP_SIGHT, 40'd1002, MIN_SIG_RESET, 2'd1, 48'hFFFF_FFFF_FFFF);
        queue_word(OP_SIGHT, 40'd1003, -8'sd86, 2'd2, 48'h3);
        queue_word(OP_SIGHT, 40'd1004, 8'sd126, 2'd3, 48'hAAAA_5555_AAAA);
        queue_word(OP_SIGHT, 40'd1005, -8'sd50, 2'd2, 48'hFFFF_FFFF_FFFF);
        queue_word(OP_SIGHT, 40'd2000, -8'sd40, 2'd0, 48'h0);
        queue_sweep(40'd3000);
        queue_word(OP_SIGHT, 40'd601002, -8'sd70, 2'd3, 48'h5555_AAAA_5555);
        queue_sweep(40'd601003);
        queue_sweep(40'd700000);
        queue_word(OP_SIGHT, 40'd900000, -8'sd20, 2'd1, 48'h1234_5678_9ABC);
        queue_word(OP_SIGHT, 40'd800000, -8'sd20, 2'd2, 48'hCBA9_8765_4321);
        queue_sweep(40'd500000);
        queue_word(OP_SIGHT, 40'hFF_FFFF_FFFF, -8'sd10, 2'd3, 48'h0);
        queue_sweep(40'hFF_FFFF_FFFF);
        queue_word(OP_SIGHT, 40'd0, -8'sd30, 2'd0, 48'h0);
        queue_word(OP_SIGHT, 40'd0, -8'sd85, 2'd0, 48'h0);

        write_min_sig(-128);
        write_reg(REG_RETENTION, 32'd1);
        clock_ms = 40'd5000;
        queue_random(100);

        write_min_sig(126);
        write_reg(REG_RETENTION, 32'hFFFF_FFFF);
        queue_random(100);

        // The hold-off lets the sender run into a full block.
        write_min_sig(-70);
        write_reg(REG_RETENTION, 32'd500);
        idle_pct = 0;
        queue_random(60);
        wait_idle();
        idle_pct = 35;
        queue_random(90);
        hold_req = 1'b1;

        write_min_sig(-100);
        write_reg(REG_RETENTION, 32'd0);
        queue_random(50);

        write_min_sig(int'($urandom_range(0, 254)) - 128);
        write_reg(REG_RETENTION, $urandom_range(1000, 2000000));
        clock_ms = {8'hFF, $urandom_range(0, 32'h7FFF_FFFF)};
        queue_random(100);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0 && expected_reports.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
